// ===== design/ci64alu_pkg.sv =====
// Shared types, opcodes and status codes of the checked 64-bit integer ALU.
package ci64alu_pkg;

  localparam int DataW  = 64;
  localparam int DivSteps = DataW;
  localparam int LastStg  = DivSteps + 1;

  localparam logic [4:0] OP_ADD = 5'd0;
  localparam logic [4:0] OP_SUB = 5'd1;
  localparam logic [4:0] OP_MUL = 5'd2;
  localparam logic [4:0] OP_DIV = 5'd3;
  localparam logic [4:0] OP_MOD = 5'd4;
  localparam logic [4:0] OP_AND = 5'd5;
  localparam logic [4:0] OP_OR  = 5'd6;
  localparam logic [4:0] OP_XOR = 5'd7;
  localparam logic [4:0] OP_SHL = 5'd8;
  localparam logic [4:0] OP_SHR = 5'd9;
  localparam logic [4:0] OP_NOT = 5'd10;
  localparam logic [4:0] OP_LT  = 5'd11;
  localparam logic [4:0] OP_GT  = 5'd12;
  localparam logic [4:0] OP_LE  = 5'd13;
  localparam logic [4:0] OP_GE  = 5'd14;
  localparam logic [4:0] OP_NE  = 5'd15;
  localparam logic [4:0] OP_EQ  = 5'd16;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_OVF   = 2'd1;
  localparam logic [1:0] ST_DIV0  = 2'd2;
  localparam logic [1:0] ST_SHIFT = 2'd3;

  typedef struct packed {
    logic [4:0]              req_type;
    logic signed [DataW-1:0] lhs_operand;
    logic signed [DataW-1:0] rhs_operand;
  } in_t;

  typedef struct packed {
    logic signed [DataW-1:0] result_value;
    logic                    compare_true;
    logic [1:0]              status_code;
  } out_t;

  // One request in flight: early results plus the divider's working state.
  typedef struct packed {
    logic [4:0]       op;
    logic [DataW-1:0] res;
    logic             cmp;
    logic [1:0]       st;
    logic             neg_a;
    logic             neg_b;
    logic [DataW-1:0] ub;
    logic [DataW-1:0] rem;
    logic [DataW-1:0] q;
  } pipe_t;

endpackage

// ===== design/checked_int64_alu_top.sv =====
// Checked 64-bit signed ALU: a deep pipeline with one restoring divide step per stage.
//
// Requests enter on in_valid/in_ready with in_data (opcode and two signed
// operands); results leave on out_valid/out_ready with out_data (result,
// comparison bit and status code). Every request gives exactly one result,
// in request order.
// Every opcode takes the same path from acceptance to out_valid: one
// input register, one stage for magnitudes and the simple operations, 64
// restoring divide stages of one quotient bit each, and the output register.
// The multiply is done as four 32x32 partial products in the second stage,
// summed and checked in the third, alongside the divider.
// Throughput is one request per cycle while the receiver takes results.
// The whole pipeline advances together: when a result waits in the output
// register and out_ready is low, every stage holds and in_ready is low, so
// nothing is lost or repeated.
// Reset (rst_n low, synchronous) clears all valid bits; the data registers
// are not reset.
module checked_int64_alu_top
  import ci64alu_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_valid,
  output logic  in_ready,
  input  in_t   in_data,
  output logic  out_valid,
  input  logic  out_ready,
  output out_t  out_data
);

  logic adv;
  in_t  in_r;
  logic in_v_r;
  pipe_t stg_r [1:LastStg];
  pipe_t stg1_nxt;
  pipe_t stg_nxt [2:LastStg];
  logic [LastStg:1] v_r;
  logic        out_valid_r;
  out_t        out_r;
  out_t        out_nxt;

  assign adv = !out_valid_r || out_ready;
  assign in_ready = adv;
  assign out_valid = out_valid_r;
  assign out_data = out_r;

  logic [31:0] pp_lo [4];
  logic [31:0] pp_hi [4];
  logic [63:0] pp_full [4];

  // Stage 1: magnitudes, error checks other than multiply overflow, and the simple operations.
  always_comb begin
    logic [DataW-1:0] a, b, s, d;
    a = in_r.lhs_operand;
    b = in_r.rhs_operand;
    s = a + b;
    d = a - b;
    stg1_nxt = '0;
    stg1_nxt.op = in_r.req_type;
    stg1_nxt.neg_a = a[DataW-1];
    stg1_nxt.neg_b = b[DataW-1];
    stg1_nxt.ub = b[DataW-1] ? (~b + 64'd1) : b;
    stg1_nxt.q  = a[DataW-1] ? (~a + 64'd1) : a;
    case (in_r.req_type)
      OP_ADD: begin
        if (((a ^ s) & (b ^ s)) >> (DataW-1) != 0) stg1_nxt.st = ST_OVF;
        else stg1_nxt.res = s;
      end
      OP_SUB: begin
        if (((a ^ b) & (a ^ d)) >> (DataW-1) != 0) stg1_nxt.st = ST_OVF;
        else stg1_nxt.res = d;
      end
      OP_DIV, OP_MOD: begin
        if (b == '0) stg1_nxt.st = ST_DIV0;
        else if (a == {1'b1, {(DataW-1){1'b0}}} && b == '1) stg1_nxt.st = ST_OVF;
      end
      OP_AND: stg1_nxt.res = a & b;
      OP_OR:  stg1_nxt.res = a | b;
      OP_XOR: stg1_nxt.res = a ^ b;
      OP_SHL, OP_SHR: begin
        if (b[DataW-1:6] != '0) stg1_nxt.st = ST_SHIFT;
        else if (in_r.req_type == OP_SHL) stg1_nxt.res = a << b[5:0];
        else stg1_nxt.res = $signed(a) >>> b[5:0];
      end
      OP_NOT: stg1_nxt.res = ~a;
      OP_LT:  stg1_nxt.cmp = $signed(a) < $signed(b);
      OP_GT:  stg1_nxt.cmp = $signed(b) < $signed(a);
      OP_LE:  stg1_nxt.cmp = !($signed(b) < $signed(a));
      OP_GE:  stg1_nxt.cmp = !($signed(a) < $signed(b));
      OP_NE:  stg1_nxt.cmp = a != b;
      OP_EQ:  stg1_nxt.cmp = a == b;
      default: ;
    endcase
  end

  // Partial products of the magnitudes, registered alongside stage 2.
  always_comb begin
    pp_full[0] = stg_r[1].q[31:0]  * stg_r[1].ub[31:0];
    pp_full[1] = stg_r[1].q[63:32] * stg_r[1].ub[31:0];
    pp_full[2] = stg_r[1].q[31:0]  * stg_r[1].ub[63:32];
    pp_full[3] = stg_r[1].q[63:32] * stg_r[1].ub[63:32];
    for (int i = 0; i < 4; i++) begin
      pp_lo[i] = pp_full[i][31:0];
      pp_hi[i] = pp_full[i][63:32];
    end
  end

  logic [31:0] pp_lo_r [4];
  logic [31:0] pp_hi_r [4];

  // Restoring divide steps: each stage brings down one dividend bit.
  always_comb begin
    for (int k = 1; k < LastStg; k++) begin
      logic [DataW:0] t;
      stg_nxt[k+1] = stg_r[k];
      t = {stg_r[k].rem, stg_r[k].q[DataW-1]} - {1'b0, stg_r[k].ub};
      if (!t[DataW]) begin
        stg_nxt[k+1].rem = t[DataW-1:0];
        stg_nxt[k+1].q = {stg_r[k].q[DataW-2:0], 1'b1};
      end else begin
        stg_nxt[k+1].rem = {stg_r[k].rem[DataW-2:0], stg_r[k].q[DataW-1]};
        stg_nxt[k+1].q = {stg_r[k].q[DataW-2:0], 1'b0};
      end
    end
    // The multiply finishes on the way into stage 3.
    begin
      logic [127:0] mag;
      logic         ovf;
      logic         differ;
      mag = {64'd0, pp_hi_r[0], pp_lo_r[0]}
          + ({64'd0, pp_hi_r[1], pp_lo_r[1]} << 32)
          + ({64'd0, pp_hi_r[2], pp_lo_r[2]} << 32)
          + ({64'd0, pp_hi_r[3], pp_lo_r[3]} << 64);
      differ = stg_r[2].neg_a != stg_r[2].neg_b;
      if (mag[127:64] != '0) ovf = 1'b1;
      else if (differ) ovf = mag[63:0] > {1'b1, 63'd0};
      else ovf = mag[63];
      if (stg_r[2].op == OP_MUL) begin
        stg_nxt[3].st  = ovf ? ST_OVF : ST_OK;
        stg_nxt[3].res = ovf ? '0 : (differ ? (~mag[63:0] + 64'd1) : mag[63:0]);
      end
    end
  end

  // Sign fix-up of quotient and remainder into the output register.
  always_comb begin
    out_nxt.result_value = stg_r[LastStg].res;
    out_nxt.compare_true = stg_r[LastStg].cmp;
    out_nxt.status_code  = stg_r[LastStg].st;
    if (stg_r[LastStg].st == ST_OK) begin
      if (stg_r[LastStg].op == OP_DIV) begin
        out_nxt.result_value = (stg_r[LastStg].neg_a != stg_r[LastStg].neg_b)
                             ? (~stg_r[LastStg].q + 64'd1) : stg_r[LastStg].q;
      end else if (stg_r[LastStg].op == OP_MOD) begin
        out_nxt.result_value = stg_r[LastStg].neg_a
                             ? (~stg_r[LastStg].rem + 64'd1) : stg_r[LastStg].rem;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
      v_r <= '0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      in_v_r <= in_valid;
      v_r <= {v_r[LastStg-1:1], in_v_r};
      out_valid_r <= v_r[LastStg];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      in_r <= in_data;
      stg_r[1] <= stg1_nxt;
      for (int k = 2; k <= LastStg; k++) stg_r[k] <= stg_nxt[k];
      for (int i = 0; i < 4; i++) begin
        pp_lo_r[i] <= pp_lo[i];
        pp_hi_r[i] <= pp_hi[i];
      end
      out_r <= out_nxt;
    end
  end

`ifndef SYNTHESIS
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.status_code != ST_OK)
      |-> (out_data.result_value == '0 && !out_data.compare_true))
    else $error("error result is not cleared");
  a_cmp_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.compare_true) |-> (out_data.status_code == ST_OK))
    else $error("comparison raised with error status");
  a_enter: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> in_v_r)
    else $error("accepted request lost at pipeline entry");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> ($stable(v_r) && $stable(pp_lo_r[0])))
    else $error("pipeline moved during stall");
`endif

endmodule

// ===== dv/tb.sv =====
// Self-checking testbench for the checked 64-bit signed ALU.
module tb;
  import ci64alu_pkg::*;

  // Expected ALU results, predicted from each accepted request and checked in order.
  class alu_result_board;
    out_t pending[$];
    int   fails;
    int   checked;

    function out_t evaluate(in_t r);
      logic signed [63:0] a;
      logic signed [63:0] b;
      logic [63:0] ua;
      logic [63:0] ub;
      logic [63:0] q;
      logic [127:0] prod;
      logic signed [127:0] sprod;
      logic [63:0] s;
      out_t o;
      a = r.lhs_operand;
      b = r.rhs_operand;
      o = '0;
      ua = a[63] ? -a : a;
      ub = b[63] ? -b : b;
      case (r.req_type)
        OP_ADD: begin
          s = a + b;
          if ((a[63] == b[63]) && (s[63] != a[63])) o.status_code = ST_OVF;
          else o.result_value = s;
        end
        OP_SUB: begin
          s = a - b;
          if ((a[63] != b[63]) && (s[63] != a[63])) o.status_code = ST_OVF;
          else o.result_value = s;
        end
        OP_MUL: begin
          sprod = 128'(a) * 128'(b);
          prod = sprod;
          if (prod[127:63] != {65{prod[63]}}) o.status_code = ST_OVF;
          else o.result_value = prod[63:0];
        end
        OP_DIV, OP_MOD: begin
          if (b == 0) o.status_code = ST_DIV0;
          else if (a == {1'b1, 63'd0} && b == -64'sd1) o.status_code = ST_OVF;
          else if (r.req_type == OP_DIV) begin
            q = ua / ub;
            o.result_value = (a[63] != b[63]) ? -q : q;
          end else begin
            q = ua % ub;
            o.result_value = a[63] ? -q : q;
          end
        end
        OP_AND: o.result_value = a & b;
        OP_OR:  o.result_value = a | b;
        OP_XOR: o.result_value = a ^ b;
        OP_SHL, OP_SHR: begin
          if ($unsigned(b) > 63) o.status_code = ST_SHIFT;
          else if (r.req_type == OP_SHL) o.result_value = a << b[5:0];
          else o.result_value = a >>> b[5:0];
        end
        OP_NOT: o.result_value = ~a;
        OP_LT: o.compare_true = a < b;
        OP_GT: o.compare_true = a > b;
        OP_LE: o.compare_true = a <= b;
        OP_GE: o.compare_true = a >= b;
        OP_NE: o.compare_true = a != b;
        OP_EQ: o.compare_true = a == b;
        default: ;
      endcase
      return o;
    endfunction

    function void note_request(in_t r);
      pending.push_back(evaluate(r));
    endfunction

    function void check_result(out_t got);
      out_t exp;
      if (pending.size() == 0) begin
        $error("result with no request outstanding");
        fails++;
        return;
      end
      exp = pending.pop_front();
      checked++;
      if (got.result_value !== exp.result_value) begin
        $error("result_value expected %0d got %0d", exp.result_value, got.result_value);
        fails++;
      end
      if (got.compare_true !== exp.compare_true) begin
        $error("compare_true expected %0d got %0d", exp.compare_true, got.compare_true);
        fails++;
      end
      if (got.status_code !== exp.status_code) begin
        $error("status_code expected %0d got %0d", exp.status_code, got.status_code);
        fails++;
      end
    endfunction
  endclass

  localparam int RandCount = 1800;
  localparam int WatchLimit = 5000;

  logic clk = 0;
  logic rst_n = 0;
  logic in_valid = 0;
  logic in_ready;
  in_t  in_data = '0;
  logic out_valid;
  logic out_ready = 0;
  out_t out_data;
  logic calm = 0;
  int   idle_cycles = 0;
  int   sent = 0;
  alu_result_board board = new();

  checked_int64_alu_top dut (.*);

  always #4 clk = ~clk;

  function logic [63:0] pick_operand();
    case ($urandom_range(0, 9))
      0: return {1'b1, 63'd0};
      1: return {1'b0, {63{1'b1}}};
      2: return 64'(signed'($urandom_range(0, 130)) - 66);
      3: return {$urandom, $urandom} >> $urandom_range(0, 63);
      4: return -({32'd0, $urandom} >> $urandom_range(0, 31));
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // Valid stays high between back-to-back requests and drops only for an idle burst.
  task automatic send_request(logic [4:0] op, logic [63:0] a, logic [63:0] b);
    if (!calm && $urandom_range(0, 5) == 0) begin
      in_valid <= 0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    in_valid <= 1;
    in_data <= '{req_type: op, lhs_operand: a, rhs_operand: b};
    do @(posedge clk); while (!in_ready);
  endtask

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) begin
        board.note_request(in_data);
        sent++;
      end
      if (out_valid && out_ready) board.check_result(out_data);
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WatchLimit) begin
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  // Receiver stalls in bursts until the final stretch.
  initial begin
    int n;
    forever begin
      @(posedge clk);
      if (!calm && $urandom_range(0, 7) == 0) begin
        n = $urandom_range(1, 11);
        out_ready <= 0;
        repeat (n) @(posedge clk);
      end
      out_ready <= 1;
    end
  end

  initial begin
    logic [63:0] mn;
    logic [63:0] mx;
    mn = {1'b1, 63'd0};
    mx = {1'b0, {63{1'b1}}};
    repeat (4) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    // Directed corners: overflow, zero divisor, MIN / -1, bad shifts, every opcode.
    send_request(OP_ADD, mx, 64'd1);
    send_request(OP_SUB, mn, 64'd1);
    send_request(OP_MUL, mn, -64'sd1);
    send_request(OP_MUL, mx, mx);
    send_request(OP_DIV, mn, -64'sd1);
    send_request(OP_MOD, mn, -64'sd1);
    send_request(OP_DIV, 64'd7, 64'd0);
    send_request(OP_MOD, -64'sd7, 64'd2);
    send_request(OP_DIV, -64'sd7, 64'd2);
    send_request(OP_AND, mn, mx);
    send_request(OP_OR, mn, mx);
    send_request(OP_XOR, '1, mx);
    send_request(OP_SHL, mx, 64'd63);
    send_request(OP_SHR, mn, 64'd63);
    send_request(OP_SHL, 64'd1, 64'd64);
    send_request(OP_SHR, 64'd1, -64'sd1);
    send_request(OP_NOT, mn, '1);
    send_request(OP_LT, mn, mx);
    send_request(OP_GT, mn, mx);
    send_request(OP_LE, 64'd5, 64'd5);
    send_request(OP_GE, -64'sd1, 64'd0);
    send_request(OP_NE, mx, mx);
    send_request(OP_EQ, mn, mn);
    send_request(5'd31, mx, mn);
    for (int i = 0; i < RandCount; i++) begin
      logic [4:0] op;
      logic [63:0] b;
      if (i > RandCount - 200) calm = 1;
      op = ($urandom_range(0, 19) == 0) ? 5'($urandom) : 5'($urandom_range(0, 16));
      b = pick_operand();
      if ((op == OP_SHL || op == OP_SHR) && $urandom_range(0, 3) != 0)
        b = 64'($urandom_range(0, 63));
      if ((op == OP_DIV || op == OP_MOD) && $urandom_range(0, 15) == 0) b = 64'd0;
      send_request(op, pick_operand(), b);
    end
    in_valid <= 0;
    while (board.pending.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
    $display("Sent %0d requests across every opcode, unused codes and edge operands;",
             sent);
    $display("%0d results compared with random stalls on both channels.", board.checked);
    if (board.fails == 0 && board.pending.size() == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end
endmodule
